/* hw/rtl/lrd_pkg.sv */
// ----------------------------------------------------------------------------
// lrd_pkg
// shared types, codes and the crc-32 byte step for the log record deframer
// ----------------------------------------------------------------------------
`default_nettype none

package lrd_pkg;

  localparam logic [31:0] CRC_PRESET = 32'hffff_ffff;
  localparam logic [31:0] CRC_POLY   = 32'hedb8_8320;

  typedef enum logic {
    ACT_BYTE = 1'b0,
    ACT_END  = 1'b1
  } action_t;

  typedef enum logic [1:0] {
    KIND_KEY    = 2'd0,
    KIND_DIGEST = 2'd1,
    KIND_ACCEPT = 2'd2,
    KIND_END    = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    STOP_NONE      = 3'd0,
    STOP_ZERO_LEN  = 3'd1,
    STOP_CRC       = 3'd2,
    STOP_MALFORMED = 3'd3,
    STOP_TRUNC     = 3'd4
  } stop_t;

  // frame position: four length bytes, body, four crc bytes
  typedef enum logic [3:0] {
    PH_LEN0 = 4'd0,
    PH_LEN1 = 4'd1,
    PH_LEN2 = 4'd2,
    PH_LEN3 = 4'd3,
    PH_BODY = 4'd4,
    PH_CRC0 = 4'd5,
    PH_CRC1 = 4'd6,
    PH_CRC2 = 4'd7,
    PH_CRC3 = 4'd8
  } phase_t;

  // body field being decoded
  typedef enum logic [3:0] {
    FLD_COMMIT = 4'd0,
    FLD_SEQ    = 4'd1,
    FLD_OP     = 4'd2,
    FLD_VER    = 4'd3,
    FLD_SIZE   = 4'd4,
    FLD_KLEN   = 4'd5,
    FLD_KEY    = 4'd6,
    FLD_DLEN   = 4'd7,
    FLD_DIG    = 4'd8,
    FLD_DONE   = 4'd9,
    FLD_FAIL   = 4'd10
  } field_t;

  typedef struct packed {
    kind_t        result_kind;
    logic [7:0]   byte_value;
    logic         commit_flag;
    logic [63:0]  sequence_res;
    logic [7:0]   operation;
    logic [63:0]  object_version;
    logic [63:0]  object_size;
    logic [31:0]  key_length;
    logic [31:0]  digest_length;
    stop_t        stop_reason;
  } res_t;

  // reflected crc-32, one byte
  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int i = 0; i < 8; i++) begin
      c = (c >> 1) ^ (c[0] ? CRC_POLY : 32'd0);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/lrd_decode.sv */
// ----------------------------------------------------------------------------
// lrd_decode
// frame state, crc and body field decode; one byte per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module lrd_decode (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          item_valid,
  input  wire logic          action,
  input  wire logic [7:0]    log_byte,
  output      logic          res_valid,
  output      lrd_pkg::res_t res
);

  lrd_pkg::phase_t phase, phase_next;
  lrd_pkg::field_t field, field_next;
  lrd_pkg::stop_t  stopped, stopped_next;
  logic [31:0] body_left, body_left_next;   // length while prefix arrives, then bytes left
  logic [31:0] running_crc, running_crc_next;
  logic [31:0] trailer_crc, trailer_crc_next;
  logic [63:0] field_shift, field_shift_next;
  logic [2:0]  field_count, field_count_next;
  logic [31:0] string_remaining, string_remaining_next;
  logic        complete, complete_next;
  logic        commit, commit_next;
  logic [63:0] seq, seq_next;
  logic [7:0]  op, op_next;
  logic [63:0] ver, ver_next;
  logic [63:0] size, size_next;
  logic [31:0] klen, klen_next;
  logic [31:0] dlen, dlen_next;

  logic        is_end, is_byte, in_body, crc_ok;
  logic [63:0] shift_in;
  logic [31:0] crc_full, len_in;
  logic        adv, take, new_frame;
  lrd_pkg::field_t tgt;

  assign is_end   = item_valid && (lrd_pkg::action_t'(action) == lrd_pkg::ACT_END);
  assign is_byte  = item_valid && (lrd_pkg::action_t'(action) == lrd_pkg::ACT_BYTE)
                    && (stopped == lrd_pkg::STOP_NONE);
  assign in_body  = is_byte && (phase == lrd_pkg::PH_BODY);
  assign shift_in = {field_shift[55:0], log_byte};
  assign len_in   = shift_in[31:0];
  assign crc_full = {trailer_crc[23:0], log_byte};
  assign crc_ok   = ((running_crc ^ lrd_pkg::CRC_PRESET) == crc_full);

  // next state
  always_comb begin
    phase_next            = phase;
    field_next            = field;
    stopped_next          = stopped;
    body_left_next        = body_left;
    running_crc_next      = running_crc;
    trailer_crc_next      = trailer_crc;
    field_shift_next      = field_shift;
    field_count_next      = field_count;
    string_remaining_next = string_remaining;
    complete_next         = complete;
    commit_next           = commit;
    seq_next              = seq;
    op_next               = op;
    ver_next              = ver;
    size_next             = size;
    klen_next             = klen;
    dlen_next             = dlen;
    adv                   = 1'b0;
    take                  = 1'b0;
    tgt                   = field;
    new_frame             = 1'b0;

    if (is_end) begin
      new_frame    = 1'b1;
      stopped_next = lrd_pkg::STOP_NONE;
    end else if (is_byte) begin
      unique case (phase)
        lrd_pkg::PH_LEN0, lrd_pkg::PH_LEN1, lrd_pkg::PH_LEN2: begin
          body_left_next = {body_left[23:0], log_byte};
          phase_next     = lrd_pkg::phase_t'(phase + 4'd1);
        end
        lrd_pkg::PH_LEN3: begin
          body_left_next = {body_left[23:0], log_byte};
          phase_next     = lrd_pkg::PH_BODY;
          if ({body_left[23:0], log_byte} == 32'd0) begin
            stopped_next = lrd_pkg::STOP_ZERO_LEN;
          end
        end
        lrd_pkg::PH_BODY: begin
          running_crc_next = lrd_pkg::crc_byte(running_crc, log_byte);
          body_left_next   = body_left - 32'd1;
          if (body_left == 32'd1) begin
            phase_next = lrd_pkg::PH_CRC0;
          end
          unique case (field)
            lrd_pkg::FLD_COMMIT: begin
              commit_next = |log_byte;
              adv = 1'b1;
              tgt = lrd_pkg::FLD_SEQ;
            end
            lrd_pkg::FLD_SEQ: begin
              if (field_count == 3'd7) begin
                seq_next = shift_in;
                adv = 1'b1;
                tgt = commit ? lrd_pkg::FLD_DONE : lrd_pkg::FLD_OP;
              end else begin
                take = 1'b1;
              end
            end
            lrd_pkg::FLD_OP: begin
              op_next = log_byte;
              adv = 1'b1;
              tgt = lrd_pkg::FLD_VER;
            end
            lrd_pkg::FLD_VER: begin
              if (field_count == 3'd7) begin
                ver_next = shift_in;
                adv = 1'b1;
                tgt = lrd_pkg::FLD_SIZE;
              end else begin
                take = 1'b1;
              end
            end
            lrd_pkg::FLD_SIZE: begin
              if (field_count == 3'd7) begin
                size_next = shift_in;
                adv = 1'b1;
                tgt = lrd_pkg::FLD_KLEN;
              end else begin
                take = 1'b1;
              end
            end
            lrd_pkg::FLD_KLEN, lrd_pkg::FLD_DLEN: begin
              if (field_count == 3'd3) begin
                adv = 1'b1;
                if (field == lrd_pkg::FLD_KLEN) begin
                  klen_next = len_in;
                end else begin
                  dlen_next = len_in;
                end
                // string length may not exceed body_left, which still counts this byte
                priority if (len_in > body_left) begin
                  tgt = lrd_pkg::FLD_FAIL;
                end else if (len_in == 32'd0) begin
                  tgt = (field == lrd_pkg::FLD_KLEN) ? lrd_pkg::FLD_DLEN : lrd_pkg::FLD_DONE;
                end else begin
                  string_remaining_next = len_in;
                  tgt = (field == lrd_pkg::FLD_KLEN) ? lrd_pkg::FLD_KEY : lrd_pkg::FLD_DIG;
                end
              end else begin
                take = 1'b1;
              end
            end
            lrd_pkg::FLD_KEY, lrd_pkg::FLD_DIG: begin
              string_remaining_next = string_remaining - 32'd1;
              if (string_remaining == 32'd1) begin
                adv = 1'b1;
                tgt = (field == lrd_pkg::FLD_KEY) ? lrd_pkg::FLD_DLEN : lrd_pkg::FLD_DONE;
              end
            end
            default: begin
            end
          endcase
        end
        lrd_pkg::PH_CRC0, lrd_pkg::PH_CRC1, lrd_pkg::PH_CRC2: begin
          trailer_crc_next = crc_full;
          phase_next       = lrd_pkg::phase_t'(phase + 4'd1);
        end
        lrd_pkg::PH_CRC3: begin
          trailer_crc_next = crc_full;
          priority if (!crc_ok) begin
            stopped_next = lrd_pkg::STOP_CRC;
          end else if (!complete) begin
            stopped_next = lrd_pkg::STOP_MALFORMED;
          end else begin
            new_frame = 1'b1;
          end
        end
        default: begin
        end
      endcase

      if (adv) begin
        field_next       = tgt;
        field_shift_next = 64'd0;
        field_count_next = 3'd0;
        if (tgt == lrd_pkg::FLD_DONE) begin
          complete_next = 1'b1;
        end
      end else if (take) begin
        field_shift_next = shift_in;
        field_count_next = field_count + 3'd1;
      end
    end

    if (new_frame) begin
      phase_next            = lrd_pkg::PH_LEN0;
      field_next            = lrd_pkg::FLD_COMMIT;
      body_left_next        = 32'd0;
      running_crc_next      = lrd_pkg::CRC_PRESET;
      trailer_crc_next      = 32'd0;
      field_shift_next      = 64'd0;
      field_count_next      = 3'd0;
      string_remaining_next = 32'd0;
      complete_next         = 1'b0;
      commit_next           = 1'b0;
      seq_next              = 64'd0;
      op_next               = 8'd0;
      ver_next              = 64'd0;
      size_next             = 64'd0;
      klen_next             = 32'd0;
      dlen_next             = 32'd0;
    end
  end

  // result of the current item
  always_comb begin
    res       = '0;
    res_valid = 1'b0;
    priority if (is_end) begin
      res_valid        = 1'b1;
      res.result_kind  = lrd_pkg::KIND_END;
      res.stop_reason  = (stopped != lrd_pkg::STOP_NONE) ? stopped :
                         ((phase != lrd_pkg::PH_LEN0) ? lrd_pkg::STOP_TRUNC
                                                      : lrd_pkg::STOP_NONE);
    end else if (in_body && (field == lrd_pkg::FLD_KEY || field == lrd_pkg::FLD_DIG)) begin
      res_valid       = 1'b1;
      res.result_kind = (field == lrd_pkg::FLD_KEY) ? lrd_pkg::KIND_KEY : lrd_pkg::KIND_DIGEST;
      res.byte_value  = log_byte;
    end else if (is_byte && phase == lrd_pkg::PH_CRC3 && crc_ok && complete) begin
      res_valid          = 1'b1;
      res.result_kind    = lrd_pkg::KIND_ACCEPT;
      res.commit_flag    = commit;
      res.sequence_res   = seq;
      res.operation      = op;
      res.object_version = ver;
      res.object_size    = size;
      res.key_length     = klen;
      res.digest_length  = dlen;
    end else begin
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= lrd_pkg::PH_LEN0;
      field            <= lrd_pkg::FLD_COMMIT;
      stopped          <= lrd_pkg::STOP_NONE;
      body_left        <= 32'd0;
      running_crc      <= lrd_pkg::CRC_PRESET;
      trailer_crc      <= 32'd0;
      field_shift      <= 64'd0;
      field_count      <= 3'd0;
      string_remaining <= 32'd0;
      complete         <= 1'b0;
      commit           <= 1'b0;
      seq              <= 64'd0;
      op               <= 8'd0;
      ver              <= 64'd0;
      size             <= 64'd0;
      klen             <= 32'd0;
      dlen             <= 32'd0;
    end else begin
      phase            <= phase_next;
      field            <= field_next;
      stopped          <= stopped_next;
      body_left        <= body_left_next;
      running_crc      <= running_crc_next;
      trailer_crc      <= trailer_crc_next;
      field_shift      <= field_shift_next;
      field_count      <= field_count_next;
      string_remaining <= string_remaining_next;
      complete         <= complete_next;
      commit           <= commit_next;
      seq              <= seq_next;
      op               <= op_next;
      ver              <= ver_next;
      size             <= size_next;
      klen             <= klen_next;
      dlen             <= dlen_next;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/lrd_out_fifo.sv */
// ----------------------------------------------------------------------------
// lrd_out_fifo
// two-entry result queue between the decoder and the output channel
// ----------------------------------------------------------------------------
`default_nettype none

module lrd_out_fifo (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  wire lrd_pkg::res_t push_data,
  output      logic          full,
  output      logic          pop_valid,
  input  wire logic          pop_ready,
  output      lrd_pkg::res_t pop_data
);

  lrd_pkg::res_t mem [2];
  logic          wr_ptr;
  logic          rd_ptr;
  logic [1:0]    count, count_next;
  logic          pop;

  assign full      = (count == 2'd2);
  assign pop_valid = (count != 2'd0);
  assign pop       = pop_valid && pop_ready;
  assign pop_data  = mem[rd_ptr];

  always_comb begin
    count_next = count;
    if (push && !pop) begin
      count_next = count + 2'd1;
    end else if (pop && !push) begin
      count_next = count - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      count <= count_next;
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/log_record_deframer_crc_check.sv */
// ----------------------------------------------------------------------------
// log_record_deframer_crc_check
// byte-stream log deframer with crc-32 check and record field decode
// ----------------------------------------------------------------------------
// Takes one log byte (or an end-of-log mark) per item and parses frames of a
// big-endian 32-bit body length, the body and a big-endian crc-32 of the body
// (reflected, preset all ones, final inversion). Key and checksum string
// bytes come out as they arrive; a frame whose crc matches and whose body
// decoded fully gives one accept item with its fields. The first bad frame
// stops parsing until end of log, whose report gives the reason and rearms
// the block. The per-byte crc step and field shift sit between the frame
// state registers and a two-entry result queue, so items flow at one per
// clock; in_ready drops only while both queue entries hold results not yet
// taken on the output channel.
// ----------------------------------------------------------------------------
`default_nettype none

module log_record_deframer_crc_check (
  input  wire logic        clk,
  input  wire logic        rst,
  // input channel
  input  wire logic        in_valid,
  output      logic        in_ready,
  input  wire logic        action,
  input  wire logic [7:0]  log_byte,
  // output channel
  output      logic        out_valid,
  input  wire logic        out_ready,
  output      logic [1:0]  result_kind,
  output      logic [7:0]  byte_value,
  output      logic        commit_flag,
  output      logic [63:0] sequence_res,
  output      logic [7:0]  operation,
  output      logic [63:0] object_version,
  output      logic [63:0] object_size,
  output      logic [31:0] key_length,
  output      logic [31:0] digest_length,
  output      logic [2:0]  stop_reason
);

  logic          accept;     // input item taken this cycle
  logic          res_valid;  // that item gives a result
  lrd_pkg::res_t res;
  lrd_pkg::res_t head;       // result at the front of the queue
  logic          full;

  // a free queue slot is always there for the result of an accepted item
  assign in_ready = !full;
  assign accept   = in_valid && in_ready;

  lrd_decode u_decode (
    .clk        (clk),
    .rst        (rst),
    .item_valid (accept),
    .action     (action),
    .log_byte   (log_byte),
    .res_valid  (res_valid),
    .res        (res)
  );

  lrd_out_fifo u_out_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (res_valid),
    .push_data (res),
    .full      (full),
    .pop_valid (out_valid),
    .pop_ready (out_ready),
    .pop_data  (head)
  );

  // unpack the queued result onto the output ports
  assign result_kind    = head.result_kind;
  assign byte_value     = head.byte_value;
  assign commit_flag    = head.commit_flag;
  assign sequence_res   = head.sequence_res;
  assign operation      = head.operation;
  assign object_version = head.object_version;
  assign object_size    = head.object_size;
  assign key_length     = head.key_length;
  assign digest_length  = head.digest_length;
  assign stop_reason    = head.stop_reason;

endmodule

`default_nettype wire
